[sv/ps2a_pkg.sv]
package ps2a_pkg;

  localparam int unsigned FIFO_DEPTH = 64;
  localparam int unsigned TABLE_SIZE = 128;
  localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);

  localparam logic [CODE_W-1:0] BREAK_PREFIX = 8'hf0;
  localparam logic [CODE_W-1:0] LSHIFT_CODE  = 8'h12;
  localparam logic [CODE_W-1:0] RSHIFT_CODE  = 8'h59;

  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic  is_read;
    char_t ch;
  } cmd_t;

  function automatic char_t layout_lookup(input logic shift, input logic [IDX_W-1:0] code);
    logic [2*CHAR_W-1:0] r;
    r = '0;
    case (code)
      7'h0e: r = {7'h60, 7'h7e};
      7'h16: r = {7'h31, 7'h21};
      7'h1e: r = {7'h32, 7'h40};
      7'h26: r = {7'h33, 7'h23};
      7'h25: r = {7'h34, 7'h24};
      7'h2e: r = {7'h35, 7'h25};
      7'h36: r = {7'h36, 7'h5e};
      7'h3d: r = {7'h37, 7'h26};
      7'h3e: r = {7'h38, 7'h2a};
      7'h46: r = {7'h39, 7'h28};
      7'h45: r = {7'h30, 7'h29};
      7'h4e: r = {7'h2d, 7'h5f};
      7'h55: r = {7'h3d, 7'h2b};
      7'h66: r = {7'h7f, 7'h7f};
      7'h0d: r = {7'h09, 7'h09};
      7'h15: r = {7'h71, 7'h51};
      7'h1d: r = {7'h77, 7'h57};
      7'h24: r = {7'h65, 7'h45};
      7'h2d: r = {7'h72, 7'h52};
      7'h2c: r = {7'h74, 7'h54};
      7'h35: r = {7'h79, 7'h59};
      7'h3c: r = {7'h75, 7'h55};
      7'h43: r = {7'h69, 7'h49};
      7'h44: r = {7'h6f, 7'h4f};
      7'h4d: r = {7'h70, 7'h50};
      7'h54: r = {7'h5b, 7'h7b};
      7'h5b: r = {7'h5d, 7'h7d};
      7'h5d: r = {7'h5c, 7'h7c};
      7'h1c: r = {7'h61, 7'h41};
      7'h1b: r = {7'h73, 7'h53};
      7'h23: r = {7'h64, 7'h44};
      7'h2b: r = {7'h66, 7'h46};
      7'h34: r = {7'h67, 7'h47};
      7'h33: r = {7'h68, 7'h48};
      7'h3b: r = {7'h6a, 7'h4a};
      7'h42: r = {7'h6b, 7'h4b};
      7'h4b: r = {7'h6c, 7'h4c};
      7'h4c: r = {7'h3b, 7'h3a};
      7'h52: r = {7'h27, 7'h22};
      7'h5a: r = {7'h0a, 7'h0a};
      7'h1a: r = {7'h7a, 7'h5a};
      7'h22: r = {7'h78, 7'h58};
      7'h21: r = {7'h63, 7'h43};
      7'h2a: r = {7'h76, 7'h56};
      7'h32: r = {7'h62, 7'h42};
      7'h31: r = {7'h6e, 7'h4e};
      7'h3a: r = {7'h6d, 7'h4d};
      7'h41: r = {7'h2c, 7'h3c};
      7'h49: r = {7'h2e, 7'h3e};
      7'h4a: r = {7'h2f, 7'h3f};
      7'h29: r = {7'h20, 7'h20};
      default: r = '0;
    endcase
    return shift ? r[CHAR_W-1:0] : r[2*CHAR_W-1:CHAR_W];
  endfunction

endpackage

[sv/ps2a_if.sv]
interface ps2a_in_if;
  import ps2a_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [CODE_W-1:0]   scan_byte;

  modport source (output valid, output action, output scan_byte, input ready);
  modport sink   (input valid, input action, input scan_byte, output ready);
endinterface

interface ps2a_out_if;
  import ps2a_pkg::*;
  logic              valid;
  logic              ready;
  logic              decoded_valid;
  logic [CHAR_W-1:0] decoded_char;
  logic              dropped;
  logic [CHAR_W-1:0] read_char;
  logic              read_empty;

  modport source (output valid, output decoded_valid, output decoded_char, output dropped,
                  output read_char, output read_empty, input ready);
  modport sink   (input valid, input decoded_valid, input decoded_char, input dropped,
                  input read_char, input read_empty, output ready);
endinterface

[sv/ps2a_front.sv]
module ps2a_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ps2a_in_if.sink         in_i,
  output logic            cmd_valid_o,
  output ps2a_pkg::cmd_t  cmd_o,
  input  logic            cmd_ready_i
);
  import ps2a_pkg::*;

  logic shift_q, shift_d;
  logic break_q, break_d;
  logic accept;
  logic is_shift;
  logic [CODE_W-1:0] code;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign accept      = in_i.valid && cmd_ready_i;
  assign code        = in_i.scan_byte;
  assign is_shift    = (code == LSHIFT_CODE) || (code == RSHIFT_CODE);

  always_comb begin
    shift_d       = shift_q;
    break_d       = break_q;
    cmd_o.is_read = (in_i.action == ACT_READ);
    cmd_o.ch      = '0;
    if (in_i.action == ACT_SCAN) begin
      if (code == BREAK_PREFIX) begin
        break_d = 1'b1;
      end else if (break_q) begin
        break_d = 1'b0;
        if (is_shift) shift_d = 1'b0;
      end else if (is_shift) begin
        shift_d = 1'b1;
      end else if (code < CODE_W'(TABLE_SIZE)) begin
        cmd_o.ch = layout_lookup(shift_q, code[IDX_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      break_q <= 1'b0;
    end else if (accept) begin
      shift_q <= shift_d;
      break_q <= break_d;
    end
  end

endmodule

[sv/ps2a_cmd_queue.sv]
module ps2a_cmd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  ps2a_pkg::cmd_t  push_cmd_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output ps2a_pkg::cmd_t  pop_cmd_o,
  input  logic            pop_ready_i
);
  import ps2a_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/ps2a_back.sv]
module ps2a_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  ps2a_pkg::cmd_t  cmd_i,
  output logic            cmd_ready_o,
  ps2a_out_if.source      out_o
);
  import ps2a_pkg::*;

  char_t            mem [FIFO_DEPTH];
  char_t            rdata_q;
  logic [PTR_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0] count_q;
  logic             out_valid_q;
  logic             dec_valid_q, dropped_q, pop_q, empty_q;
  char_t            dec_char_q;
  logic             load, push_en, pop_en, full, empty, has_char;

  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign load        = cmd_valid_i && cmd_ready_o;
  assign full        = (count_q == CNT_W'(FIFO_DEPTH));
  assign empty       = (count_q == '0);
  assign has_char    = (cmd_i.ch != '0);
  assign pop_en      = load && cmd_i.is_read && !empty;
  assign push_en     = load && !cmd_i.is_read && has_char && !full;

  always_ff @(posedge clk_i) begin
    if (push_en) mem[tail_q] <= cmd_i.ch;
    if (pop_en)  rdata_q     <= mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dec_valid_q <= !cmd_i.is_read && has_char;
      dec_char_q  <= cmd_i.is_read ? '0 : cmd_i.ch;
      dropped_q   <= !cmd_i.is_read && has_char && full;
      pop_q       <= cmd_i.is_read && !empty;
      empty_q     <= cmd_i.is_read && empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
    end else begin
      if (cmd_ready_o) out_valid_q <= cmd_valid_i;
      if (pop_en) begin
        head_q  <= (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
        count_q <= count_q - CNT_W'(1);
      end
      if (push_en) begin
        tail_q  <= (tail_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.decoded_valid = dec_valid_q;
  assign out_o.decoded_char  = dec_char_q;
  assign out_o.dropped       = dropped_q;
  assign out_o.read_char     = pop_q ? rdata_q : '0;
  assign out_o.read_empty    = empty_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("fifo count above depth");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !cmd_i.is_read && has_char && full |=> out_valid_q && dropped_q && dec_valid_q)
    else $error("full fifo push not flagged as dropped");

  a_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (pop_q || empty_q) |-> !dec_valid_q && !dropped_q)
    else $error("read result carries decode flags");

  a_pop_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_en |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not decrement count");

endmodule

[sv/ps2_scancode_to_ascii_fifo_top.sv]
// PS/2 set-2 keyboard decoder with a character buffer. Each input transfer carries either a
// received scancode byte or a read request, and each yields exactly one output transfer.
// A front stage tracks shift and break-prefix state and looks up the ASCII code; a two-entry
// command queue decouples it from the back stage, which owns the 64-entry character buffer
// and the output register. One item is taken per cycle when the output side keeps up; each
// input transfer is held first in a queue slot and then in the output register, while the
// buffer read is registered alongside the latter. A character arriving with the buffer full
// is still reported but flagged dropped; a read with the buffer empty returns zero with
// read_empty set.
module ps2_scancode_to_ascii_fifo_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  ps2a_in_if.sink      in_i,
  ps2a_out_if.source   out_o
);
  import ps2a_pkg::*;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  ps2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  ps2a_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_cmd_i   (front_cmd),
    .push_ready_o (front_ready),
    .pop_valid_o  (back_valid),
    .pop_cmd_o    (back_cmd),
    .pop_ready_i  (back_ready)
  );

  ps2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_i       (back_cmd),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule
